// ----- hw/rtl/ibus_frame_receiver_unit_macros.svh -----
// ---------------------------------------------------------------------------
// ibus frame receiver assertion macros
// shared property forms for the checker
// ---------------------------------------------------------------------------
`ifndef IBUS_FRAME_RECEIVER_UNIT_MACROS_SVH
`define IBUS_FRAME_RECEIVER_UNIT_MACROS_SVH

// same-cycle implication
`define IBFR_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ibfr property violated");

// next-cycle implication
`define IBFR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ibfr property violated");

`endif

// ----- hw/rtl/ibfr_pkg.sv -----
// ---------------------------------------------------------------------------
// ibfr_pkg
// constants and types shared by the ibus frame receiver
// ---------------------------------------------------------------------------
package ibfr_pkg;

   localparam int CHANNELS    = 14;
   localparam int IDX_W       = 4;
   localparam int POS_W       = 5;
   localparam int RAW_W       = 16;
   localparam int NORM_W      = 16;
   localparam int DZ_W        = 15;
   localparam int MAG_W       = 15;
   localparam int DATA_W      = 8;
   localparam int RSP_DATA_W  = 40;

   localparam logic [DATA_W-1:0] HDR_FIRST  = 8'h20;
   localparam logic [DATA_W-1:0] HDR_SECOND = 8'h40;

   localparam logic [POS_W-1:0] POS_HUNT    = 5'd0;
   localparam logic [POS_W-1:0] POS_HDR2    = 5'd1;
   localparam logic [POS_W-1:0] POS_BODY    = 5'd2;
   localparam logic [POS_W-1:0] POS_CSUM_LO = 5'd30;
   localparam logic [POS_W-1:0] POS_LAST    = 5'd31;

   // 0xffff minus both header bytes
   localparam logic [15:0] SUM_INIT = 16'hFFFF - 16'(HDR_FIRST) - 16'(HDR_SECOND);

   localparam int CENTRE     = 1500;
   localparam int HALF_SPAN  = 500;
   localparam int FULL_SCALE = 16384;

   // floor(a * 4096 / 125) == (a * RECIP) >> 16 for a up to HALF_SPAN
   localparam int RECIP_W = 22;
   localparam int PROD_W  = 31;
   localparam logic [RECIP_W-1:0] RECIP = 22'd2147484;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   typedef struct packed {
      logic [IDX_W-1:0] index;
      logic [RAW_W-1:0] raw;
      logic             last;
   } chan_item_type;

   typedef struct packed {
      logic [FIFO_CNT_W-1:0] count;
      logic                  empty;
      logic                  full;
   } fifo_stat_type;

endpackage

// ----- hw/rtl/ibfr_fifo.sv -----
// ---------------------------------------------------------------------------
// ibfr_fifo
// short queue of channel items between frame front end and scaling back end
// ---------------------------------------------------------------------------
module ibfr_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  ibfr_pkg::chan_item_type push_item,
   input  logic                   pop,
   output ibfr_pkg::chan_item_type pop_item,
   output ibfr_pkg::fifo_stat_type stat
);
   import ibfr_pkg::*;

   chan_item_type         slot_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wptr_ff, wptr_in;
   logic [FIFO_PTR_W-1:0] rptr_ff, rptr_in;
   logic [FIFO_CNT_W-1:0] count_ff, count_in;
   logic                  do_push, do_pop;

   assign do_push = push && (count_ff != FIFO_CNT_W'(FIFO_DEPTH));
   assign do_pop  = pop && (count_ff != '0);

   always_comb begin
      wptr_in  = do_push ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in  = do_pop ? rptr_ff + 1'b1 : rptr_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wptr_ff] <= push_item;
      end
   end

   assign pop_item   = slot_ff[rptr_ff];
   assign stat.count = count_ff;
   assign stat.empty = (count_ff == '0);
   assign stat.full  = (count_ff == FIFO_CNT_W'(FIFO_DEPTH));

endmodule

// ----- hw/rtl/ibfr_front.sv -----
// ---------------------------------------------------------------------------
// ibfr_front
// header hunt, channel capture, checksum check and readout of good frames
// ---------------------------------------------------------------------------
module ibfr_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [7:0]              req_tdata,
   input  ibfr_pkg::fifo_stat_type q_stat,
   output logic                    q_push,
   output ibfr_pkg::chan_item_type q_item
);
   import ibfr_pkg::*;

   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [15:0]       sum_ff, sum_in;
   logic [7:0]        low_ff, low_in;
   logic              sweep_ff, sweep_in;
   logic [IDX_W-1:0]  cnt_ff, cnt_in;
   logic              rd_valid_ff;
   logic [IDX_W-1:0]  rd_idx_ff;
   logic [RAW_W-1:0]  rd_data_ff;
   logic [RAW_W-1:0]  chan_mem_ff [CHANNELS];

   logic              accept;
   logic              mem_we;
   logic [IDX_W-1:0]  mem_waddr;
   logic              issue;
   logic [FIFO_CNT_W-1:0] pending;

   assign req_tready = !sweep_ff;
   assign accept     = req_tvalid && req_tready;
   assign mem_waddr  = pos_ff[POS_W-1:1] - 1'b1;
   assign pending    = q_stat.count + FIFO_CNT_W'(rd_valid_ff);
   assign issue      = sweep_ff && (pending < FIFO_CNT_W'(FIFO_DEPTH));

   always_comb begin
      pos_in   = pos_ff;
      sum_in   = sum_ff;
      low_in   = low_ff;
      sweep_in = sweep_ff;
      cnt_in   = cnt_ff;
      mem_we   = 1'b0;
      if (accept) begin
         case (pos_ff)
            POS_HUNT: begin
               if (req_tdata == HDR_FIRST) begin
                  pos_in = POS_HDR2;
               end
            end
            POS_HDR2: begin
               if (req_tdata == HDR_SECOND) begin
                  pos_in = POS_BODY;
                  sum_in = SUM_INIT;
               end else if (req_tdata == HDR_FIRST) begin
                  pos_in = POS_HDR2;
               end else begin
                  pos_in = POS_HUNT;
               end
            end
            POS_LAST: begin
               pos_in = POS_HUNT;
               if ({req_tdata, low_ff} == sum_ff) begin
                  sweep_in = 1'b1;
                  cnt_in   = '0;
               end
            end
            default: begin
               pos_in = pos_ff + 1'b1;
               if (!pos_ff[0]) begin
                  low_in = req_tdata;
               end
               if (pos_ff < POS_CSUM_LO) begin
                  sum_in = sum_ff - 16'(req_tdata);
                  mem_we = pos_ff[0] && (mem_waddr < IDX_W'(CHANNELS));
               end
            end
         endcase
      end
      if (issue) begin
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == IDX_W'(CHANNELS - 1)) begin
            sweep_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= POS_HUNT;
         sweep_ff    <= 1'b0;
         cnt_ff      <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         pos_ff      <= pos_in;
         sweep_ff    <= sweep_in;
         cnt_ff      <= cnt_in;
         rd_valid_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
      low_ff <= low_in;
      if (mem_we) begin
         chan_mem_ff[mem_waddr] <= {req_tdata, low_ff};
      end
      if (issue) begin
         rd_data_ff <= chan_mem_ff[cnt_ff];
         rd_idx_ff  <= cnt_ff;
      end
   end

   assign q_push       = rd_valid_ff;
   assign q_item.index = rd_idx_ff;
   assign q_item.raw   = rd_data_ff;
   assign q_item.last  = (rd_idx_ff == IDX_W'(CHANNELS - 1));

endmodule

// ----- hw/rtl/ibfr_back.sv -----
// ---------------------------------------------------------------------------
// ibfr_back
// three-stage scaling of raw channel values with clamp and deadzone
// ---------------------------------------------------------------------------
module ibfr_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [14:0]             deadzone,
   input  ibfr_pkg::fifo_stat_type q_stat,
   input  ibfr_pkg::chan_item_type q_item,
   output logic                    q_pop,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [39:0]             rsp_tdata,
   output logic                    rsp_tlast
);
   import ibfr_pkg::*;

   logic              advance;

   // stage 1: centre and magnitude
   logic              s1_valid_ff;
   chan_item_type     s1_item_ff;
   logic              s1_neg_ff, s1_big_ff;
   logic [8:0]        s1_mag_ff;
   logic [16:0]       diff, abs_diff;

   // stage 2: reciprocal multiply
   logic              s2_valid_ff;
   chan_item_type     s2_item_ff;
   logic              s2_neg_ff, s2_big_ff;
   logic [PROD_W-1:0] s2_prod_ff;

   // stage 3: output register
   logic              out_valid_ff;
   chan_item_type     out_item_ff;
   logic [NORM_W-1:0] out_norm_ff, out_norm_in;
   logic [MAG_W-1:0]  mag;

   assign advance = !out_valid_ff || rsp_tready;
   assign q_pop   = advance && !q_stat.empty;

   assign diff     = {1'b0, q_item.raw} - 17'(CENTRE);
   assign abs_diff = diff[16] ? (17'd0 - diff) : diff;

   always_comb begin
      mag = s2_big_ff ? MAG_W'(FULL_SCALE) : s2_prod_ff[PROD_W-1:16];
      if ({1'b0, mag} < {1'b0, deadzone}) begin
         out_norm_in = '0;
      end else if (s2_neg_ff) begin
         out_norm_in = NORM_W'(0) - {1'b0, mag};
      end else begin
         out_norm_in = {1'b0, mag};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= !q_stat.empty;
         s2_valid_ff  <= s1_valid_ff;
         out_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_item_ff  <= q_item;
         s1_neg_ff   <= diff[16];
         s1_big_ff   <= abs_diff > 17'(HALF_SPAN);
         s1_mag_ff   <= abs_diff[8:0];
         s2_item_ff  <= s1_item_ff;
         s2_neg_ff   <= s1_neg_ff;
         s2_big_ff   <= s1_big_ff;
         s2_prod_ff  <= PROD_W'(s1_mag_ff) * PROD_W'(RECIP);
         out_item_ff <= s2_item_ff;
         out_norm_ff <= out_norm_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = out_item_ff.last;
   assign rsp_tdata  = {4'd0, out_norm_ff, out_item_ff.raw, out_item_ff.index};

endmodule

// ----- hw/rtl/ibus_frame_receiver_unit.sv -----
// ---------------------------------------------------------------------------
// ibus_frame_receiver_unit
// byte-serial receiver for 32-byte ibus style frames with channel scaling
// ---------------------------------------------------------------------------
// req channel takes one serial byte per transfer; the front end hunts for
// the header, stores channel words and checks the trailing checksum.
// after the last byte of a good frame the front end reads the 14 stored
// channel words out of its channel memory, one per cycle through its single
// read port while the queue has room, and holds req_tready low until all 14
// are read; bad frames give no transfers and no stall.
// rsp channel gives one transfer per channel through the queue and the back
// end pipeline; while rsp is not stalled the transfers follow one per cycle.
// a stalled rsp channel fills the 4-entry queue and then holds the readout.
// csr channel writes the deadzone and is always ready.
// reset returns the receiver to header hunt with an empty queue and a zero
// deadzone.
// ---------------------------------------------------------------------------
module ibus_frame_receiver_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // channel_index, raw_value, normalised_value, zero pad
   output logic        rsp_tlast,   // last_channel
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [14:0] csr_data     // deadzone
);
   import ibfr_pkg::*;

   logic [DZ_W-1:0] deadzone_ff;
   logic [DZ_W-1:0] deadzone_in;
   fifo_stat_type   q_stat;
   chan_item_type   push_item;
   chan_item_type   pop_item;
   logic            q_push;
   logic            q_pop;

   assign csr_ready   = 1'b1;
   assign deadzone_in = (csr_valid && csr_ready) ? csr_data : deadzone_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         deadzone_ff <= '0;
      end else begin
         deadzone_ff <= deadzone_in;
      end
   end

   ibfr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_stat     (q_stat),
      .q_push     (q_push),
      .q_item     (push_item)
   );

   ibfr_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .pop       (q_pop),
      .pop_item  (pop_item),
      .stat      (q_stat)
   );

   ibfr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .deadzone   (deadzone_ff),
      .q_stat     (q_stat),
      .q_item     (pop_item),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ----- hw/rtl/ibfr_checker.sv -----
// ---------------------------------------------------------------------------
// ibfr_checker
// port-level properties of the ibus frame receiver
// ---------------------------------------------------------------------------
`include "ibus_frame_receiver_unit_macros.svh"

module ibfr_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic        rsp_tlast
);
   import ibfr_pkg::*;

   logic [3:0]  chan;
   logic [15:0] norm;
   logic [40:0] rsp_word;
   logic        stalled;
   logic        norm_ok;

   assign chan     = rsp_tdata[3:0];
   assign norm     = rsp_tdata[35:20];
   assign rsp_word = {rsp_tlast, rsp_tdata};
   assign stalled  = rsp_tvalid && !rsp_tready;
   assign norm_ok  = (!norm[15] && norm <= 16'h4000) || (norm[15] && norm >= 16'hC000);

   `IBFR_ASSERT_NEXT(a_rsp_hold, clock, reset, stalled, rsp_tvalid && $stable(rsp_word))
   `IBFR_ASSERT_SAME(a_chan_range, clock, reset, rsp_tvalid, chan < 4'(CHANNELS))
   `IBFR_ASSERT_SAME(a_last_chan, clock, reset, rsp_tvalid && rsp_tlast, chan == 4'(CHANNELS - 1))
   `IBFR_ASSERT_SAME(a_norm_range, clock, reset, rsp_tvalid, norm_ok)

endmodule

bind ibus_frame_receiver_unit ibfr_checker u_checker (.*);

// ----- dv/ibus_frame_receiver_unit_checker.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// ibus frame receiver channel checker
// follows every byte transfer on req, rebuilds the frame, checks its sum and
// predicts the channel transfers; compares each rsp transfer field by field
// ---------------------------------------------------------------------------
module ibus_frame_receiver_unit_checker
   import ibfr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,
   input  logic        rsp_tlast,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [14:0] csr_data,
   output int          fail_count,
   output int          pending_count,
   output int          checked_count,
   output int          good_frames
);

   typedef struct {
      logic [IDX_W-1:0]         index;
      logic [RAW_W-1:0]         raw;
      logic signed [NORM_W-1:0] norm;
      logic                     last;
   } chan_result_type;

   chan_result_type  pending_channels[$];
   logic [POS_W-1:0] byte_pos = POS_HUNT;
   logic [7:0]       frame_bytes [32];
   logic [DZ_W-1:0]  deadzone = '0;
   int               fails = 0;
   int               checked = 0;
   int               frames = 0;

   function automatic logic signed [NORM_W-1:0] scale_raw(input logic [RAW_W-1:0] raw,
                                                          input logic [DZ_W-1:0]  dz);
      int offset;
      int scaled;
      int mag;
      offset = int'(raw) - CENTRE;
      scaled = offset * FULL_SCALE / HALF_SPAN;
      if (scaled > FULL_SCALE) scaled = FULL_SCALE;
      if (scaled < -FULL_SCALE) scaled = -FULL_SCALE;
      mag = (scaled < 0) ? -scaled : scaled;
      if (mag < int'(dz)) scaled = 0;
      return NORM_W'(scaled);
   endfunction

   task automatic decode_frame();
      logic [15:0]     sum_check;
      logic [15:0]     received;
      chan_result_type r;
      sum_check = 16'hFFFF;
      for (int i = 0; i < int'(POS_CSUM_LO); i++) sum_check -= 16'(frame_bytes[i]);
      received = {frame_bytes[POS_LAST], frame_bytes[POS_CSUM_LO]};
      if (received == sum_check) begin
         frames++;
         for (int k = 0; k < CHANNELS; k++) begin
            r.index = IDX_W'(k);
            r.raw   = {frame_bytes[int'(POS_BODY) + 2*k + 1], frame_bytes[int'(POS_BODY) + 2*k]};
            r.norm  = scale_raw(r.raw, deadzone);
            r.last  = (k == CHANNELS - 1);
            pending_channels.push_back(r);
         end
      end
   endtask

   task automatic absorb_byte(input logic [7:0] b);
      case (byte_pos)
         POS_HUNT: begin
            if (b == HDR_FIRST) begin
               frame_bytes[POS_HUNT] = b;
               byte_pos = POS_HDR2;
            end
         end
         POS_HDR2: begin
            if (b == HDR_SECOND) begin
               frame_bytes[POS_HDR2] = b;
               byte_pos = POS_BODY;
            end else if (b == HDR_FIRST) begin
               frame_bytes[POS_HUNT] = b;
            end else begin
               byte_pos = POS_HUNT;
            end
         end
         default: begin
            frame_bytes[byte_pos] = b;
            if (byte_pos == POS_LAST) begin
               byte_pos = POS_HUNT;
               decode_frame();
            end else begin
               byte_pos = byte_pos + 1'b1;
            end
         end
      endcase
   endtask

   task automatic compare_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         fails++;
      end
   endtask

   always @(posedge clock) begin
      chan_result_type got;
      chan_result_type want;
      if (reset) begin
         pending_channels.delete();
         byte_pos = POS_HUNT;
         deadzone = '0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.index = rsp_tdata[IDX_W-1:0];
            got.raw   = rsp_tdata[IDX_W +: RAW_W];
            got.norm  = rsp_tdata[IDX_W+RAW_W +: NORM_W];
            got.last  = rsp_tlast;
            if (pending_channels.size() == 0) begin
               $error("unexpected channel transfer: channel_index %0d, raw_value %0d",
                      got.index, got.raw);
               fails++;
            end else begin
               want = pending_channels.pop_front();
               compare_field("channel_index", want.index, got.index);
               compare_field("raw_value", want.raw, got.raw);
               compare_field("normalised_value", int'(want.norm), int'(got.norm));
               compare_field("last_channel", want.last, got.last);
               checked++;
            end
         end
         if (csr_valid && csr_ready) deadzone = csr_data;
         if (req_tvalid && req_tready) absorb_byte(req_tdata);
      end
      fail_count    <= fails;
      pending_count <= pending_channels.size();
      checked_count <= checked;
      good_frames   <= frames;
   end

endmodule

// ----- dv/ibus_frame_receiver_unit_test.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// ibus frame receiver testbench
// streams serial bytes into the receiver: stray bytes, broken headers, good
// and corrupted frames, under several deadzone settings and idle patterns,
// with one long rsp hold-off; a separate checker predicts the channels
// ---------------------------------------------------------------------------
module ibus_frame_receiver_unit_test;
   import ibfr_pkg::*;

   localparam int ITEM_TARGET    = 410;
   localparam int DIRECTED_ITEMS = 70;
   // each phase overshoots its budget by about half a frame
   localparam int PHASE_ITEMS    = (ITEM_TARGET - DIRECTED_ITEMS) / 5 - 16;
   localparam int HOLD_CYCLES    = 400;
   localparam int SETTLE_CYCLES  = 32;
   localparam int DRAIN_CYCLES   = 40;
   localparam int CYCLE_LIMIT    = 300000;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;    // data_byte
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;    // channel_index, raw_value, normalised_value, zero pad
   logic        rsp_tlast;    // last_channel
   logic        csr_valid;
   logic        csr_ready;
   logic [14:0] csr_data;     // deadzone

   int fail_count;
   int pending_count;
   int checked_count;
   int good_frames;

   int req_idle_pct = 8;
   int rsp_idle_pct = 81;
   bit hold_off_pending = 1'b0;
   bit hold_off_done = 1'b0;
   int items_sent = 0;
   int cycle_count = 0;

   logic [RAW_W-1:0] chan_words [CHANNELS];

   always #6 clock = ~clock;

   ibus_frame_receiver_unit dut (.*);

   ibus_frame_receiver_unit_checker channel_scoreboard (.*);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("ibus_frame_receiver_unit test failed");
         $finish;
      end
   end

   // rsp side back-pressure, with one long hold-off on request
   initial begin
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_pending && !hold_off_done) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_off_done = 1'b1;
         end
         rsp_tready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   task automatic send_frame(input bit corrupt);
      logic [7:0]  fb [32];
      logic [15:0] sum;
      int          pos;
      fb[POS_HUNT] = HDR_FIRST;
      fb[POS_HDR2] = HDR_SECOND;
      for (int k = 0; k < CHANNELS; k++) begin
         fb[int'(POS_BODY) + 2*k]     = chan_words[k][7:0];
         fb[int'(POS_BODY) + 2*k + 1] = chan_words[k][15:8];
      end
      sum = 16'hFFFF;
      for (int i = 0; i < int'(POS_CSUM_LO); i++) sum -= 16'(fb[i]);
      fb[POS_CSUM_LO] = sum[7:0];
      fb[POS_LAST]    = sum[15:8];
      if (corrupt) begin
         pos = $urandom_range(31, 2);
         fb[pos] = fb[pos] ^ 8'($urandom_range(255, 1));
      end
      for (int i = 0; i < 32; i++) send_byte(fb[i]);
   endtask

   function automatic logic [RAW_W-1:0] random_channel();
      case ($urandom_range(9))
         0, 1, 2, 3, 4, 5: return RAW_W'($urandom_range(2100, 900));
         6, 7:             return RAW_W'($urandom_range(16'hFFFF));
         8: begin
            case ($urandom_range(4))
               0:       return 16'd1000;
               1:       return 16'd2000;
               2:       return 16'd0;
               3:       return 16'hFFFF;
               default: return 16'd1500;
            endcase
         end
         default:          return RAW_W'($urandom_range(1540, 1460));
      endcase
   endfunction

   task automatic fill_random_channels();
      for (int k = 0; k < CHANNELS; k++) chan_words[k] = random_channel();
   endtask

   task automatic set_deadzone(input logic [DZ_W-1:0] value);
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic run_random_phase(input int budget);
      int         start;
      int         pick;
      logic [7:0] b;
      start = items_sent;
      while (items_sent - start < budget) begin
         pick = $urandom_range(99);
         if (pick < 72) begin
            fill_random_channels();
            send_frame(1'b0);
         end else if (pick < 84) begin
            fill_random_channels();
            send_frame(1'b1);
         end else if (pick < 92) begin
            // stray bytes while hunting
            repeat ($urandom_range(4, 1)) begin
               b = 8'($urandom_range(255));
               if (b == HDR_FIRST) b = ~HDR_FIRST;
               send_byte(b);
            end
         end else begin
            // header start followed by a wrong second byte
            b = 8'($urandom_range(255));
            if (b == HDR_SECOND || b == HDR_FIRST) b = b ^ 8'h01;
            send_byte(HDR_FIRST);
            send_byte(b);
         end
      end
   endtask

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      csr_valid  <= 1'b0;
      csr_data   <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      set_deadzone('0);
      // ignored bytes while hunting
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(HDR_SECOND);
      // wrong second byte drops back to hunting
      send_byte(HDR_FIRST);
      send_byte(8'hBF);
      // repeated first header byte restarts the frame
      send_byte(HDR_FIRST);
      chan_words = '{16'd0, 16'hFFFF, 16'd1000, 16'd2000, 16'd1500, 16'd1499, 16'd1501,
                     16'd999, 16'd2001, 16'h00FF, 16'hFF00, 16'd1469, 16'd1531, 16'd1532};
      send_frame(1'b0);
      send_frame(1'b1);

      set_deadzone(DZ_W'(FULL_SCALE));
      run_random_phase(PHASE_ITEMS);

      req_idle_pct = 81;
      rsp_idle_pct = 8;
      set_deadzone(DZ_W'(1));
      run_random_phase(PHASE_ITEMS);
      set_deadzone('1);
      run_random_phase(PHASE_ITEMS);

      req_idle_pct = 0;
      rsp_idle_pct = 0;
      set_deadzone(DZ_W'($urandom_range(FULL_SCALE - 1, 2)));
      hold_off_pending = 1'b1;
      run_random_phase(PHASE_ITEMS);
      set_deadzone(DZ_W'(FULL_SCALE + 1));
      run_random_phase(PHASE_ITEMS);

      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run covered %0d bytes in, %0d good frames, %0d channel transfers compared",
               items_sent, good_frames, checked_count);
      $display("deadzones 0, 1, full scale, above full scale, all ones and one random value");
      if (fail_count == 0) begin
         $display("ibus_frame_receiver_unit test passed");
      end else begin
         $display("ibus_frame_receiver_unit test failed");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/ibfr_pkg.sv
hw/rtl/ibfr_fifo.sv
hw/rtl/ibfr_front.sv
hw/rtl/ibfr_back.sv
hw/rtl/ibus_frame_receiver_unit.sv
hw/rtl/ibfr_checker.sv
dv/ibus_frame_receiver_unit_checker.sv
dv/ibus_frame_receiver_unit_test.sv
